@@ rtl/core/wzht_pkg.sv @@
// ----------------------------------------------------------------------------
// Window stacking order package
// Shared types, codes and sizes for the window stacking order hit tester.
// ----------------------------------------------------------------------------
package wzht_pkg;

   localparam int MAX_WINDOWS = 16;
   localparam int IDX_BITS    = $clog2(MAX_WINDOWS);
   localparam int CNT_BITS    = $clog2(MAX_WINDOWS + 1);
   localparam int COORD_BITS  = 12;
   localparam int ID_BITS     = 16;

   typedef enum logic [1:0] {
      REQ_ALLOC    = 2'd0,
      REQ_RELEASE  = 2'd1,
      REQ_ACTIVATE = 2'd2,
      REQ_HIT      = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_NO_ID    = 2'd2,
      ST_NO_POINT = 2'd3
   } status_code_type;

   typedef enum logic [1:0] {
      NOTE_NONE      = 2'd0,
      NOTE_ALLOCATED = 2'd1,
      NOTE_RELEASED  = 2'd2,
      NOTE_ACTIVATED = 2'd3
   } notice_code_type;

   typedef enum logic [1:0] {
      CELL_HOLD  = 2'd0,
      CELL_LOAD  = 2'd1,
      CELL_SHIFT = 2'd2,
      CELL_CLEAR = 2'd3
   } cell_op_type;

   typedef struct packed {
      logic                  valid;
      logic                  act;
      logic [ID_BITS-1:0]    id;
      logic [ID_BITS-1:0]    pid;
      logic [COORD_BITS-1:0] left;
      logic [COORD_BITS-1:0] top;
      logic [COORD_BITS-1:0] right;
      logic [COORD_BITS-1:0] bottom;
   } entry_type;

   typedef struct packed {
      cell_op_type op;
      logic        act_wr;
      logic        act_val;
   } cell_ctl_type;

   typedef struct packed {
      logic [ID_BITS-1:0]    target;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } query_type;

endpackage

@@ rtl/core/wzht_cell.sv @@
// ----------------------------------------------------------------------------
// Stacking order cell
// Holds one stack position and takes its upper neighbor's window on a shift.
// ----------------------------------------------------------------------------
module wzht_cell (
   input  logic                clock,
   input  logic                reset,
   input  wzht_pkg::cell_ctl_type ctl,
   input  wzht_pkg::entry_type upper,
   input  wzht_pkg::entry_type load_entry,
   input  wzht_pkg::query_type query,
   output wzht_pkg::entry_type entry,
   output logic                match,
   output logic                hit
);

   wzht_pkg::entry_type entry_ff, entry_in;
   logic                match_ff, hit_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         wzht_pkg::CELL_HOLD:  entry_in = entry_ff;
         wzht_pkg::CELL_LOAD:  entry_in = load_entry;
         wzht_pkg::CELL_SHIFT: entry_in = upper;
         wzht_pkg::CELL_CLEAR: begin
            entry_in.valid = 1'b0;
            entry_in.act   = 1'b0;
         end
         default:              entry_in = entry_ff;
      endcase
      if (ctl.act_wr) begin
         entry_in.act = ctl.act_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
         entry_ff.act   <= 1'b0;
         match_ff       <= 1'b0;
         hit_ff         <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         match_ff <= entry_ff.valid && (query.target != '0) && (entry_ff.id == query.target);
         hit_ff   <= entry_ff.valid && (entry_ff.left <= query.x) && (entry_ff.right > query.x)
                     && (entry_ff.top <= query.y) && (entry_ff.bottom > query.y);
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;
   assign hit   = hit_ff;

endmodule

@@ rtl/core/window_zorder_hit_test_top.sv @@
// ----------------------------------------------------------------------------
// Window stacking order hit tester
// Keeps up to sixteen windows in bottom-to-top order and serves allocate,
// release, activate and point hit test requests.
// ----------------------------------------------------------------------------
// Usage: drive the req_ ports and raise start while busy is low; the request
// is taken at that clock edge and busy goes high. The row of stack cells
// compares every window against the request, a priority pick selects the
// position, and the row then loads, shifts or clears cells. The result
// appears on the rsp_ ports, marked by rsp_valid high for exactly one cycle;
// busy is low in that same cycle, so the next request can be taken at the
// edge that ends it, but not before the last result is out. The receiver
// cannot stall; results are never held back. Reset empties the stack,
// clears the active window and restarts window ids at one; no clearing pass
// is needed.
// ----------------------------------------------------------------------------
module window_zorder_hit_test_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [11:0] req_rect_left,
   input  logic [11:0] req_rect_top,
   input  logic [11:0] req_rect_right,
   input  logic [11:0] req_rect_bottom,
   input  logic [15:0] req_owner_pid,
   input  logic [15:0] req_target_id,
   input  logic [11:0] req_point_x,
   input  logic [11:0] req_point_y,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_found_id,
   output logic [15:0] rsp_found_pid,
   output logic        rsp_notice_valid,
   output logic [15:0] rsp_notice_pid,
   output logic [1:0]  rsp_notice_kind,
   output logic [15:0] rsp_active_id
);

   localparam int N = wzht_pkg::MAX_WINDOWS;
   localparam int IB = wzht_pkg::IDX_BITS;
   localparam int CB = wzht_pkg::CNT_BITS;

   typedef enum logic [2:0] {S_IDLE, S_EVAL, S_PICK, S_APPLY, S_RESP} state_type;

   state_type                    state_ff;
   wzht_pkg::req_code_type       op_ff;
   wzht_pkg::entry_type          new_ff;
   wzht_pkg::query_type          query_ff;
   logic [CB-1:0]                count_ff;
   logic [15:0]                  next_id_ff;
   logic [IB-1:0]                pos_ff, pos_in;
   logic                         found_ff, found_in;
   wzht_pkg::entry_type          sel_ff;
   logic                         rsp_valid_ff;
   logic [1:0]                   status_ff;
   logic [15:0]                  fid_ff, fpid_ff, npid_ff, active_ff;
   logic                         nvalid_ff;
   logic [1:0]                   nkind_ff;

   wzht_pkg::entry_type          entries [N];
   wzht_pkg::entry_type          uppers [N];
   wzht_pkg::cell_ctl_type       ctls [N];
   logic [N-1:0]                 match_bits, hits;
   wzht_pkg::entry_type          load_entry;
   logic [15:0]                  active_id;
   logic                         on_top;

   assign load_entry = (op_ff == wzht_pkg::REQ_ALLOC) ? new_ff : sel_ff;
   assign on_top     = (CB'(pos_ff) + CB'(1)) == count_ff;

   always_comb begin
      found_in = 1'b0;
      pos_in   = '0;
      if (op_ff == wzht_pkg::REQ_HIT) begin
         for (int i = 0; i < N; i++) begin
            if (hits[i]) begin
               found_in = 1'b1;
               pos_in   = IB'(i);
            end
         end
      end else begin
         for (int i = N - 1; i >= 0; i--) begin
            if (match_bits[i]) begin
               found_in = 1'b1;
               pos_in   = IB'(i);
            end
         end
      end
   end

   always_comb begin
      active_id = '0;
      for (int i = 0; i < N; i++) begin
         if (entries[i].valid && entries[i].act) begin
            active_id = active_id | entries[i].id;
         end
      end
   end

   for (genvar g = 0; g < N; g++) begin : g_cell
      if (g == N - 1) begin : g_last
         assign uppers[g] = '0;
      end else begin : g_mid
         assign uppers[g] = entries[g + 1];
      end

      always_comb begin
         ctls[g] = '{op: wzht_pkg::CELL_HOLD, act_wr: 1'b0, act_val: 1'b0};
         if (state_ff == S_APPLY) begin
            case (op_ff)
               wzht_pkg::REQ_ALLOC: begin
                  if (count_ff != CB'(N)) begin
                     ctls[g].act_wr  = 1'b1;
                     ctls[g].act_val = (CB'(g) == count_ff);
                     if (CB'(g) == count_ff) begin
                        ctls[g].op = wzht_pkg::CELL_LOAD;
                     end
                  end
               end
               wzht_pkg::REQ_RELEASE: begin
                  if (found_ff) begin
                     if ((CB'(g) + CB'(1)) == count_ff) begin
                        ctls[g].op = wzht_pkg::CELL_CLEAR;
                     end else if (IB'(g) >= pos_ff && (CB'(g) + CB'(1)) < count_ff) begin
                        ctls[g].op = wzht_pkg::CELL_SHIFT;
                     end
                  end
               end
               wzht_pkg::REQ_ACTIVATE: begin
                  if (found_ff) begin
                     ctls[g].act_wr = 1'b1;
                     if (on_top) begin
                        ctls[g].act_val = (IB'(g) == pos_ff);
                     end else if ((CB'(g) + CB'(1)) == count_ff) begin
                        ctls[g].op      = wzht_pkg::CELL_LOAD;
                        ctls[g].act_val = 1'b1;
                     end else if (IB'(g) >= pos_ff && (CB'(g) + CB'(1)) < count_ff) begin
                        ctls[g].op = wzht_pkg::CELL_SHIFT;
                     end
                  end
               end
               default: ctls[g].op = wzht_pkg::CELL_HOLD;
            endcase
         end
      end

      wzht_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctls[g]),
         .upper      (uppers[g]),
         .load_entry (load_entry),
         .query      (query_ff),
         .entry      (entries[g]),
         .match      (match_bits[g]),
         .hit        (hits[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         next_id_ff   <= 16'd1;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff          <= wzht_pkg::req_code_type'(req_type);
                  new_ff.valid   <= 1'b1;
                  new_ff.act     <= 1'b1;
                  new_ff.id      <= next_id_ff;
                  new_ff.pid     <= req_owner_pid;
                  new_ff.left    <= req_rect_left;
                  new_ff.top     <= req_rect_top;
                  new_ff.right   <= req_rect_right;
                  new_ff.bottom  <= req_rect_bottom;
                  query_ff.target <= req_target_id;
                  query_ff.x     <= req_point_x;
                  query_ff.y     <= req_point_y;
                  state_ff       <= S_EVAL;
               end
            end
            S_EVAL: state_ff <= S_PICK;
            S_PICK: begin
               found_ff <= found_in;
               pos_ff   <= pos_in;
               sel_ff   <= entries[pos_in];
               state_ff <= S_APPLY;
            end
            S_APPLY: begin
               case (op_ff)
                  wzht_pkg::REQ_ALLOC: begin
                     if (count_ff != CB'(N)) begin
                        count_ff   <= count_ff + CB'(1);
                        next_id_ff <= (next_id_ff == 16'hFFFF) ? 16'd1 : next_id_ff + 16'd1;
                     end
                  end
                  wzht_pkg::REQ_RELEASE: begin
                     if (found_ff) begin
                        count_ff <= count_ff - CB'(1);
                     end
                  end
                  default: count_ff <= count_ff;
               endcase
               state_ff <= S_RESP;
            end
            S_RESP: begin
               rsp_valid_ff <= 1'b1;
               status_ff    <= wzht_pkg::ST_OK;
               fid_ff       <= '0;
               fpid_ff      <= '0;
               nvalid_ff    <= 1'b0;
               npid_ff      <= '0;
               nkind_ff     <= wzht_pkg::NOTE_NONE;
               active_ff    <= active_id;
               case (op_ff)
                  wzht_pkg::REQ_ALLOC: begin
                     if (new_ff.id == next_id_ff) begin
                        status_ff <= wzht_pkg::ST_FULL;
                     end else begin
                        fid_ff    <= new_ff.id;
                        fpid_ff   <= new_ff.pid;
                        nvalid_ff <= 1'b1;
                        npid_ff   <= new_ff.pid;
                        nkind_ff  <= wzht_pkg::NOTE_ALLOCATED;
                     end
                  end
                  wzht_pkg::REQ_RELEASE: begin
                     if (!found_ff) begin
                        status_ff <= wzht_pkg::ST_NO_ID;
                     end else if (count_ff != '0) begin
                        nvalid_ff <= 1'b1;
                        npid_ff   <= entries[0].pid;
                        nkind_ff  <= wzht_pkg::NOTE_RELEASED;
                     end
                  end
                  wzht_pkg::REQ_ACTIVATE: begin
                     if (!found_ff) begin
                        status_ff <= wzht_pkg::ST_NO_ID;
                     end else if (!on_top) begin
                        nvalid_ff <= 1'b1;
                        npid_ff   <= entries[0].pid;
                        nkind_ff  <= wzht_pkg::NOTE_ACTIVATED;
                     end
                  end
                  wzht_pkg::REQ_HIT: begin
                     if (!found_ff) begin
                        status_ff <= wzht_pkg::ST_NO_POINT;
                     end else begin
                        fid_ff  <= sel_ff.id;
                        fpid_ff <= sel_ff.pid;
                     end
                  end
                  default: status_ff <= wzht_pkg::ST_OK;
               endcase
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_found_id     = fid_ff;
   assign rsp_found_pid    = fpid_ff;
   assign rsp_notice_valid = nvalid_ff;
   assign rsp_notice_pid   = npid_ff;
   assign rsp_notice_kind  = nkind_ff;
   assign rsp_active_id    = active_ff;

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Window stacking order hit tester testbench
// Drives allocate, release, activate and hit test requests into the block,
// keeps its own model of the window table and stacking order, and compares
// every response field against the predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   typedef struct {
      wzht_pkg::req_code_type kind;
      logic [11:0]     left, top, right, bottom;
      logic [15:0]     owner, target;
      logic [11:0]     px, py;
   } request_type;

   typedef struct {
      wzht_pkg::status_code_type status;
      logic [15:0]     found_id, found_pid;
      logic            note_valid;
      logic [15:0]     note_pid;
      wzht_pkg::notice_code_type note_kind;
      logic [15:0]     active_id;
   } response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = 2'd0;
   logic [11:0] req_rect_left = '0, req_rect_top = '0;
   logic [11:0] req_rect_right = '0, req_rect_bottom = '0;
   logic [15:0] req_owner_pid = '0, req_target_id = '0;
   logic [11:0] req_point_x = '0, req_point_y = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_found_id, rsp_found_pid;
   logic        rsp_notice_valid;
   logic [15:0] rsp_notice_pid;
   logic [1:0]  rsp_notice_kind;
   logic [15:0] rsp_active_id;

   // Window table model.
   logic [15:0] win_id [wzht_pkg::MAX_WINDOWS];
   logic [15:0] win_pid [wzht_pkg::MAX_WINDOWS];
   logic [11:0] win_rect [wzht_pkg::MAX_WINDOWS][4];
   int          z_order [wzht_pkg::MAX_WINDOWS];
   int          z_count = 0;
   logic [15:0] next_id = 16'd1;
   int          focus_slot = 0;
   bit          focus_valid = 0;

   response_type pending_q[$];
   int  errors = 0;
   int  quiet_cycles = 0;
   bit  no_gaps = 0;

   window_zorder_hit_test_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int find_window(logic [15:0] id);
      if (id == 0) return -1;
      for (int i = 0; i < z_count; i++)
         if (win_id[z_order[i]] == id) return i;
      return -1;
   endfunction

   function automatic void unlink_window(int pos);
      for (int i = pos; i + 1 < z_count; i++) z_order[i] = z_order[i + 1];
      z_count--;
   endfunction

   function automatic response_type apply_request(request_type r);
      response_type e;
      int s;
      int pos;
      e = '{wzht_pkg::ST_OK, 16'd0, 16'd0, 1'b0, 16'd0, wzht_pkg::NOTE_NONE, 16'd0};
      case (r.kind)
         wzht_pkg::REQ_ALLOC: begin
            s = 0;
            while (s < wzht_pkg::MAX_WINDOWS && win_id[s] != 0) s++;
            if (s == wzht_pkg::MAX_WINDOWS || z_count >= wzht_pkg::MAX_WINDOWS) begin
               e.status = wzht_pkg::ST_FULL;
            end else begin
               win_id[s] = next_id;
               next_id = (next_id == 16'hFFFF) ? 16'd1 : next_id + 16'd1;
               win_pid[s] = r.owner;
               win_rect[s] = '{r.left, r.top, r.right, r.bottom};
               z_order[z_count] = s;
               z_count++;
               focus_slot = s;
               focus_valid = 1;
               e.found_id = win_id[s];
               e.found_pid = r.owner;
               e.note_valid = 1'b1;
               e.note_pid = r.owner;
               e.note_kind = wzht_pkg::NOTE_ALLOCATED;
            end
         end
         wzht_pkg::REQ_RELEASE: begin
            pos = find_window(r.target);
            if (pos < 0) begin
               e.status = wzht_pkg::ST_NO_ID;
            end else begin
               s = z_order[pos];
               unlink_window(pos);
               win_id[s] = 16'd0;
               if (focus_valid && focus_slot == s) focus_valid = 0;
               if (z_count > 0) begin
                  e.note_valid = 1'b1;
                  e.note_pid = win_pid[z_order[0]];
                  e.note_kind = wzht_pkg::NOTE_RELEASED;
               end
            end
         end
         wzht_pkg::REQ_ACTIVATE: begin
            pos = find_window(r.target);
            if (pos < 0) begin
               e.status = wzht_pkg::ST_NO_ID;
            end else begin
               s = z_order[pos];
               focus_slot = s;
               focus_valid = 1;
               if (pos + 1 != z_count) begin
                  unlink_window(pos);
                  z_order[z_count] = s;
                  z_count++;
                  e.note_valid = 1'b1;
                  e.note_pid = win_pid[z_order[0]];
                  e.note_kind = wzht_pkg::NOTE_ACTIVATED;
               end
            end
         end
         default: begin
            e.status = wzht_pkg::ST_NO_POINT;
            for (int i = z_count - 1; i >= 0; i--) begin
               s = z_order[i];
               if (win_rect[s][0] <= r.px && win_rect[s][2] > r.px &&
                   win_rect[s][1] <= r.py && win_rect[s][3] > r.py) begin
                  e.status = wzht_pkg::ST_OK;
                  e.found_id = win_id[s];
                  e.found_pid = win_pid[s];
                  break;
               end
            end
         end
      endcase
      e.active_id = focus_valid ? win_id[focus_slot] : 16'd0;
      return e;
   endfunction

   // Issues one request and records its predicted response once taken.
   task automatic send_request(request_type r);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_type <= r.kind;
      req_rect_left <= r.left;
      req_rect_top <= r.top;
      req_rect_right <= r.right;
      req_rect_bottom <= r.bottom;
      req_owner_pid <= r.owner;
      req_target_id <= r.target;
      req_point_x <= r.px;
      req_point_y <= r.py;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_q.push_back(apply_request(r));
   endtask

   function automatic request_type make_request(wzht_pkg::req_code_type k);
      request_type r;
      r = '{k, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
            16'($urandom), 16'($urandom), 12'($urandom), 12'($urandom)};
      return r;
   endfunction

   task automatic alloc_window(int l, int t, int rt, int b, int pid);
      request_type r;
      r = make_request(wzht_pkg::REQ_ALLOC);
      r.left = 12'(l); r.top = 12'(t); r.right = 12'(rt); r.bottom = 12'(b);
      r.owner = 16'(pid);
      send_request(r);
   endtask

   task automatic target_window(wzht_pkg::req_code_type k, logic [15:0] id);
      request_type r;
      r = make_request(k);
      r.target = id;
      send_request(r);
   endtask

   task automatic probe_point(int x, int y);
      request_type r;
      r = make_request(wzht_pkg::REQ_HIT);
      r.px = 12'(x); r.py = 12'(y);
      send_request(r);
   endtask

   task automatic test_directed();
      target_window(wzht_pkg::REQ_RELEASE, 16'd5);
      probe_point(0, 0);
      alloc_window(10, 10, 20, 20, 16'h1234);
      target_window(wzht_pkg::REQ_RELEASE, 16'd1);
      alloc_window(0, 0, 4095, 4095, 16'hFFFF);
      alloc_window(100, 100, 100, 200, 16'h0000);
      alloc_window(300, 300, 200, 200, 16'h5A5A);
      alloc_window(50, 60, 70, 80, 16'hA5A5);
      probe_point(4094, 4094);
      probe_point(4095, 4095);
      probe_point(150, 100);
      probe_point(250, 250);
      probe_point(50, 60);
      probe_point(69, 79);
      probe_point(70, 79);
      target_window(wzht_pkg::REQ_ACTIVATE, 16'd5);
      target_window(wzht_pkg::REQ_ACTIVATE, 16'd2);
      target_window(wzht_pkg::REQ_ACTIVATE, 16'd0);
      target_window(wzht_pkg::REQ_RELEASE, 16'd0);
      target_window(wzht_pkg::REQ_RELEASE, 16'd2);
      target_window(wzht_pkg::REQ_ACTIVATE, 16'hFFFF);
      target_window(wzht_pkg::REQ_RELEASE, 16'd4);
   endtask

   // Fills the table past its capacity, then works on the bottom windows.
   task automatic test_table_full();
      for (int i = 0; i < wzht_pkg::MAX_WINDOWS + 2; i++) begin
         alloc_window($urandom_range(0, 2000), $urandom_range(0, 2000),
            $urandom_range(2000, 4095), $urandom_range(2000, 4095),
            $urandom_range(0, 65535));
      end
      for (int i = 0; i < 6; i++) begin
         target_window(wzht_pkg::REQ_ACTIVATE, win_id[z_order[0]]);
         probe_point(2000, 2000);
         target_window(wzht_pkg::REQ_RELEASE, win_id[z_order[z_count - 1]]);
      end
   endtask

   task automatic test_random(int count);
      request_type r;
      int pick, s;
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            r = make_request(wzht_pkg::REQ_ALLOC);
            if ($urandom_range(0, 9) < 7) begin
               r.left = 12'($urandom_range(0, 3000));
               r.top = 12'($urandom_range(0, 3000));
               r.right = 12'(r.left + $urandom_range(1, 4095 - r.left));
               r.bottom = 12'(r.top + $urandom_range(1, 4095 - r.top));
            end
         end else begin
            r = make_request(pick < 50 ? wzht_pkg::REQ_RELEASE :
                             pick < 75 ? wzht_pkg::REQ_ACTIVATE : wzht_pkg::REQ_HIT);
            if (z_count > 0 && $urandom_range(0, 9) < 8) begin
               s = z_order[$urandom_range(0, z_count - 1)];
               r.target = win_id[s];
               if (win_rect[s][2] > win_rect[s][0] && win_rect[s][3] > win_rect[s][1]) begin
                  r.px = 12'(win_rect[s][0] + $urandom % (win_rect[s][2] - win_rect[s][0]));
                  r.py = 12'(win_rect[s][1] + $urandom % (win_rect[s][3] - win_rect[s][1]));
               end
            end else if ($urandom_range(0, 3) == 0) begin
               r.target = 16'd0;
            end
         end
         send_request(r);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_q.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            response_type e;
            e = pending_q.pop_front();
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_found_id !== e.found_id) begin
               $error("found_id expected %0d actual %0d", e.found_id, rsp_found_id);
               errors++;
            end
            if (rsp_found_pid !== e.found_pid) begin
               $error("found_pid expected %0d actual %0d", e.found_pid, rsp_found_pid);
               errors++;
            end
            if (rsp_notice_valid !== e.note_valid) begin
               $error("notice_valid expected %0d actual %0d", e.note_valid,
                      rsp_notice_valid);
               errors++;
            end
            if (rsp_notice_pid !== e.note_pid) begin
               $error("notice_pid expected %0d actual %0d", e.note_pid, rsp_notice_pid);
               errors++;
            end
            if (rsp_notice_kind !== e.note_kind) begin
               $error("notice_kind expected %0d actual %0d", e.note_kind,
                      rsp_notice_kind);
               errors++;
            end
            if (rsp_active_id !== e.active_id) begin
               $error("active_id expected %0d actual %0d", e.active_id, rsp_active_id);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= 2000) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < wzht_pkg::MAX_WINDOWS; i++) begin
         win_id[i] = 16'd0;
         win_pid[i] = 16'd0;
         win_rect[i] = '{12'd0, 12'd0, 12'd0, 12'd0};
         z_order[i] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_table_full();
      test_random(1700);
      start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
